FILE: sv/qft_pkg.sv
// Shared types, constants and helper functions for the query filter tokenizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package qft_pkg;

  localparam int MAX_WORD   = 16;
  localparam int MAX_TAG    = 64;
  localparam int WCW        = $clog2(MAX_WORD + 1);
  localparam int FIFO_DEPTH = 4;
  localparam int FPW        = $clog2(FIFO_DEPTH);
  localparam int FCW        = $clog2(FIFO_DEPTH + 1);
  localparam int NUM_KW     = 8;

  localparam logic [63:0] MAG_CAP     = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_CAP_M1  = MAG_CAP - 64'd1;
  localparam logic [63:0] MAG_CAP_D10 = MAG_CAP / 64'd10;

  // Byte codes of interest
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  // Keyword text, right-justified; first character in the highest used byte
  localparam logic [63:0] KW_TEXT [NUM_KW] = '{
    64'("not"), 64'("and"), 64'("or"), 64'("priority"),
    64'("lte"), 64'("gte"), 64'("gt"), 64'("lt")
  };
  localparam logic [3:0] KW_LEN [NUM_KW] = '{
    4'd3, 4'd3, 4'd2, 4'd8, 4'd3, 4'd3, 4'd2, 4'd2
  };

  typedef enum logic [3:0] {
    KIND_EOF      = 4'd0,
    KIND_LPAREN   = 4'd1,
    KIND_RPAREN   = 4'd2,
    KIND_TAG_BYTE = 4'd3,
    KIND_TAG_END  = 4'd4,
    KIND_NOT      = 4'd5,
    KIND_AND      = 4'd6,
    KIND_OR       = 4'd7,
    KIND_PRIORITY = 4'd8,
    KIND_LTE      = 4'd9,
    KIND_GTE      = 4'd10,
    KIND_GT       = 4'd11,
    KIND_LT       = 4'd12,
    KIND_INT      = 4'd13,
    KIND_ERROR    = 4'd14
  } qft_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_UNKNOWN  = 2'd1,
    ERR_TAG_LONG = 2'd2
  } qft_err_e;

  typedef enum logic [3:0] {
    MODE_IDLE = 4'b0001,
    MODE_WORD = 4'b0010,
    MODE_TAG  = 4'b0100,
    MODE_HALT = 4'b1000
  } qft_mode_e;

  // Integer parse phases
  localparam logic [2:0] NPH_START   = 3'd0;
  localparam logic [2:0] NPH_PLUS    = 3'd1;
  localparam logic [2:0] NPH_MINUS   = 3'd2;
  localparam logic [2:0] NPH_POS     = 3'd3;
  localparam logic [2:0] NPH_NEG     = 3'd4;
  localparam logic [2:0] NPH_POS_END = 3'd5;
  localparam logic [2:0] NPH_NEG_END = 3'd6;
  localparam logic [2:0] NPH_BAD     = 3'd7;

  typedef struct packed {
    qft_kind_e          kind;
    logic signed [63:0] int_value;
    logic [7:0]         tag_byte;
    logic [7:0]         word_length;
    qft_err_e           error_code;
    logic [15:0]        error_position;
    logic               last_result;
  } qft_res_t;

  // Results caused by one byte; second one only valid when two is set
  typedef struct packed {
    qft_res_t r0;
    qft_res_t r1;
    logic     two;
  } qft_pair_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [63:0] acc;
  } qft_num_t;

  function automatic qft_kind_e qft_kw_kind(input logic [2:0] k);
    qft_kind_e kd;
    case (k)
      3'd0:    kd = KIND_NOT;
      3'd1:    kd = KIND_AND;
      3'd2:    kd = KIND_OR;
      3'd3:    kd = KIND_PRIORITY;
      3'd4:    kd = KIND_LTE;
      3'd5:    kd = KIND_GTE;
      3'd6:    kd = KIND_GT;
      default: kd = KIND_LT;
    endcase
    return kd;
  endfunction

  function automatic logic [7:0] qft_kw_char(input int k, input logic [2:0] i);
    logic [2:0] sel;
    sel = 3'(KW_LEN[k] - {1'b0, i} - 4'd1);
    return KW_TEXT[k][{sel, 3'b000} +: 8];
  endfunction

  // Advance the keyword prefix match by one byte at position cnt
  function automatic logic [NUM_KW-1:0] qft_kw_step(input logic [NUM_KW-1:0] mask,
                                                     input logic [WCW-1:0] cnt,
                                                     input logic [7:0] b);
    logic [NUM_KW-1:0] m;
    for (int k = 0; k < NUM_KW; k++) begin
      m[k] = mask[k] && (cnt < WCW'(KW_LEN[k])) && (b == qft_kw_char(k, cnt[2:0]));
    end
    return m;
  endfunction

  // One byte of strtol-style parsing with magnitude saturation
  function automatic qft_num_t qft_num_feed(input logic [2:0] ph, input logic [63:0] acc,
                                            input logic [7:0] b);
    qft_num_t    o;
    logic        dig;
    logic [63:0] d;
    logic [63:0] v;
    o.phase = ph;
    o.acc   = acc;
    dig     = (b >= CH_ZERO) && (b <= CH_NINE);
    d       = {60'd0, b[3:0]};
    v       = (acc << 3) + (acc << 1) + d;
    case (ph)
      NPH_START: begin
        if (b >= CH_TAB && b <= CH_CR) begin
          o.phase = ph;
        end else if (b == CH_PLUS) begin
          o.phase = NPH_PLUS;
        end else if (b == CH_MINUS) begin
          o.phase = NPH_MINUS;
        end else if (dig) begin
          o.acc   = d;
          o.phase = NPH_POS;
        end else begin
          o.phase = NPH_BAD;
        end
      end
      NPH_PLUS, NPH_MINUS: begin
        if (dig) begin
          o.acc   = d;
          o.phase = (ph == NPH_PLUS) ? NPH_POS : NPH_NEG;
        end else begin
          o.phase = NPH_BAD;
        end
      end
      NPH_POS, NPH_NEG: begin
        if (dig) begin
          if (acc > MAG_CAP_D10) o.acc = MAG_CAP;
          else o.acc = (v > MAG_CAP) ? MAG_CAP : v;
        end else begin
          o.phase = (ph == NPH_POS) ? NPH_POS_END : NPH_NEG_END;
        end
      end
      default: begin
        o.phase = ph;
      end
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: sv/qft_front.sv
// Front end: scans query bytes, tracks word/tag/number state, forms result pairs.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qft_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic [7:0]        query_byte_i,
  output logic                   pair_valid_o,
  output qft_pkg::qft_pair_t     pair_o
);
  import qft_pkg::*;

  qft_mode_e         mode_q, mode_d;
  logic [WCW-1:0]    wcnt_q, wcnt_d;
  logic [7:0]        tcnt_q, tcnt_d;
  logic [63:0]       acc_q, acc_d;
  logic [2:0]        ph_q, ph_d;
  logic [15:0]       off_q, off_d;
  logic [NUM_KW-1:0] kw_q, kw_d;

  qft_res_t          r0, r1, ir;
  logic              has0, has1, iemit, idle, sep, cont, kw_hit;
  logic [2:0]        kw_idx;
  qft_num_t          feed;
  logic [NUM_KW-1:0] kwm;

  always_comb begin
    mode_d = mode_q;
    wcnt_d = wcnt_q;
    tcnt_d = tcnt_q;
    acc_d  = acc_q;
    ph_d   = ph_q;
    off_d  = off_q;
    kw_d   = kw_q;
    r0     = '0;
    r1     = '0;
    ir     = '0;
    has0   = 1'b0;
    has1   = 1'b0;
    iemit  = 1'b0;
    idle   = 1'b0;
    kw_hit = 1'b0;
    kw_idx = '0;

    sep  = (query_byte_i == CH_SPACE) || (query_byte_i == CH_NUL) ||
           (query_byte_i == CH_LPAREN) || (query_byte_i == CH_RPAREN);
    cont = (mode_q == MODE_WORD) && !sep && (wcnt_q < WCW'(MAX_WORD));
    // a fresh word starts from a clean parser and a full keyword mask
    feed = qft_num_feed(cont ? ph_q : NPH_START, cont ? acc_q : '0, query_byte_i);
    kwm  = qft_kw_step(cont ? kw_q : '1, cont ? wcnt_q : '0, query_byte_i);

    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (kw_q[k] && (wcnt_q == WCW'(KW_LEN[k]))) begin
        kw_hit = 1'b1;
        kw_idx = 3'(k);
      end
    end

    if (mode_q != MODE_HALT) off_d = off_q + 16'd1;

    case (mode_q)
      MODE_WORD: begin
        if (cont) begin
          wcnt_d = wcnt_q + WCW'(1);
          ph_d   = feed.phase;
          acc_d  = feed.acc;
          kw_d   = kwm;
        end else begin
          has0           = 1'b1;
          r0.word_length = 8'(wcnt_q);
          mode_d         = MODE_IDLE;
          idle           = 1'b1;
          if (kw_hit) begin
            r0.kind = qft_kw_kind(kw_idx);
          end else if (ph_q == NPH_POS || ph_q == NPH_POS_END) begin
            r0.kind      = KIND_INT;
            r0.int_value = (acc_q > MAG_CAP_M1) ? MAG_CAP_M1 : acc_q;
          end else if (ph_q == NPH_NEG || ph_q == NPH_NEG_END) begin
            r0.kind      = KIND_INT;
            r0.int_value = (~acc_q) + 64'd1;
          end else begin
            r0.kind           = KIND_ERROR;
            r0.error_code     = ERR_UNKNOWN;
            r0.error_position = off_q - 16'(wcnt_q) + 16'd1;
            mode_d            = MODE_HALT;
            idle              = 1'b0;
          end
        end
      end
      MODE_TAG: begin
        has0 = 1'b1;
        if (!sep) begin
          if (({1'b0, tcnt_q} + 9'd1) < 9'(MAX_TAG)) begin
            r0.kind     = KIND_TAG_BYTE;
            r0.tag_byte = query_byte_i;
            tcnt_d      = tcnt_q + 8'd1;
          end else begin
            r0.kind           = KIND_ERROR;
            r0.word_length    = tcnt_q;
            r0.error_code     = ERR_TAG_LONG;
            r0.error_position = off_q - {8'd0, tcnt_q} + 16'd1;
            mode_d            = MODE_HALT;
          end
        end else begin
          r0.kind        = KIND_TAG_END;
          r0.word_length = tcnt_q;
          mode_d         = MODE_IDLE;
          idle           = 1'b1;
        end
      end
      MODE_IDLE: begin
        idle = 1'b1;
      end
      default: begin
        idle = 1'b0;
      end
    endcase

    // between tokens
    if (idle) begin
      if (query_byte_i == CH_NUL) begin
        iemit   = 1'b1;
        ir.kind = KIND_EOF;
        mode_d  = MODE_IDLE;
        wcnt_d  = '0;
        tcnt_d  = '0;
        acc_d   = '0;
        ph_d    = NPH_START;
        off_d   = '0;
      end else if (query_byte_i == CH_LPAREN) begin
        iemit          = 1'b1;
        ir.kind        = KIND_LPAREN;
        ir.word_length = 8'd1;
      end else if (query_byte_i == CH_RPAREN) begin
        iemit          = 1'b1;
        ir.kind        = KIND_RPAREN;
        ir.word_length = 8'd1;
      end else if (query_byte_i == CH_DOT) begin
        mode_d = MODE_TAG;
        tcnt_d = '0;
      end else if (query_byte_i != CH_SPACE) begin
        mode_d = MODE_WORD;
        wcnt_d = WCW'(1);
        ph_d   = feed.phase;
        acc_d  = feed.acc;
        kw_d   = kwm;
      end
      if (iemit) begin
        if (has0) begin
          r1   = ir;
          has1 = 1'b1;
        end else begin
          r0   = ir;
          has0 = 1'b1;
        end
      end
    end

    r0.last_result = !has1;
    r1.last_result = 1'b1;
  end

  assign pair_valid_o = in_valid_i && has0;
  assign pair_o       = '{r0: r0, r1: r1, two: has1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      wcnt_q <= '0;
      tcnt_q <= '0;
      acc_q  <= '0;
      ph_q   <= NPH_START;
      off_q  <= '0;
      kw_q   <= '0;
    end else if (in_valid_i) begin
      mode_q <= mode_d;
      wcnt_q <= wcnt_d;
      tcnt_q <= tcnt_d;
      acc_q  <= acc_d;
      ph_q   <= ph_d;
      off_q  <= off_d;
      kw_q   <= kw_d;
    end
  end

  // once halted, only reset leaves the halt
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HALT) |=> (mode_q == MODE_HALT))
    else $error("halt left without reset");

  a_word_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wcnt_q <= WCW'(MAX_WORD)))
    else $error("word count beyond limit");

  a_tag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, tcnt_q} < 9'(MAX_TAG)))
    else $error("tag count beyond limit");

endmodule

`default_nettype wire

FILE: sv/qft_fifo.sv
// Short queue of result pairs between the front end and the output stage.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qft_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire qft_pkg::qft_pair_t wdata_i,
  input  wire logic               rd_i,
  output logic                    full_o,
  output logic                    empty_o,
  output qft_pkg::qft_pair_t      rdata_o
);
  import qft_pkg::*;

  qft_pair_t      mem_q [FIFO_DEPTH];
  logic [FPW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [FCW-1:0] cnt_q, cnt_d;
  logic           do_wr, do_rd;

  assign full_o  = (cnt_q == FCW'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  always_comb begin
    wptr_d = do_wr ? wptr_q + FPW'(1) : wptr_q;
    rptr_d = do_rd ? rptr_q + FPW'(1) : rptr_q;
    cnt_d  = cnt_q + FCW'(do_wr) - FCW'(do_rd);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wptr_q] <= wdata_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_i && full_o))
    else $error("pair queue written while full");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("pointers disagree with fill count");

endmodule

`default_nettype wire

FILE: sv/qft_back.sv
// Output stage: takes result pairs from the queue and hands them out one at a time.
// Depends on qft_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qft_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fifo_empty_i,
  input  wire qft_pkg::qft_pair_t fifo_rdata_i,
  output logic                    fifo_rd_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output qft_pkg::qft_res_t       res_o
);
  import qft_pkg::*;

  qft_pair_t head_q;
  logic      hv_q, hv_d;
  logic      idx_q, idx_d;
  logic      done, advance;

  assign done      = idx_q || !head_q.two;
  assign advance   = !hv_q || (pop_i && done);
  assign fifo_rd_o = advance && !fifo_empty_i;
  assign empty_o   = !hv_q;
  assign res_o     = idx_q ? head_q.r1 : head_q.r0;

  always_comb begin
    hv_d  = hv_q;
    idx_d = idx_q;
    if (advance) begin
      hv_d  = !fifo_empty_i;
      idx_d = 1'b0;
    end else if (pop_i) begin
      idx_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hv_q  <= 1'b0;
      idx_q <= 1'b0;
    end else begin
      hv_q  <= hv_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fifo_rd_o) head_q <= fifo_rdata_i;
  end

  // the second slot is only ever shown for a pair that carries two results
  a_idx_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hv_q && idx_q) |-> head_q.two)
    else $error("second result shown for single-result pair");

endmodule

`default_nettype wire

FILE: sv/query_filter_tokenizer_unit.sv
// Query filter tokenizer: one query byte in per cycle while not full, tokens out one per
// cycle while pop is held and results wait. Each result passes the pair queue and then the
// output stage's head register. Throughput: one byte per cycle while each byte yields at
// most one token and results are popped; a two-token byte gives two results, one per pop,
// absorbed by a four-pair queue. Asynchronous active-low reset returns to idle between tokens.
// Depends on qft_pkg, qft_front, qft_fifo, qft_back.
`timescale 1ns / 1ps
`default_nettype none

module query_filter_tokenizer_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  query_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       token_kind_o,
  output logic signed [63:0] int_value_o,
  output logic [7:0]       tag_byte_o,
  output logic [7:0]       word_length_o,
  output logic [1:0]       error_code_o,
  output logic [15:0]      error_position_o,
  output logic             last_result_o
);
  import qft_pkg::*;

  logic      in_acc, pair_valid, fifo_empty, fifo_rd;
  qft_pair_t pair, fifo_rdata;
  qft_res_t  res;

  assign in_acc = push && !full;

  qft_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_acc),
    .query_byte_i (query_byte_i),
    .pair_valid_o (pair_valid),
    .pair_o       (pair)
  );

  qft_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (pair_valid),
    .wdata_i (pair),
    .rd_i    (fifo_rd),
    .full_o  (full),
    .empty_o (fifo_empty),
    .rdata_o (fifo_rdata)
  );

  qft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_rdata_i (fifo_rdata),
    .fifo_rd_o    (fifo_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  assign token_kind_o     = res.kind;
  assign int_value_o      = res.int_value;
  assign tag_byte_o       = res.tag_byte;
  assign word_length_o    = res.word_length;
  assign error_code_o     = res.error_code;
  assign error_position_o = res.error_position;
  assign last_result_o    = res.last_result;

endmodule

`default_nettype wire

FILE: dv/query_filter_tokenizer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for query_filter_tokenizer_unit: query bytes go in through
// push/full, tokens are predicted by a local scanner and checked as they leave on pop/empty.
// Depends on qft_pkg and query_filter_tokenizer_unit.

module query_filter_tokenizer_unit_tb;
  import qft_pkg::*;

  typedef logic [7:0] byte_q_t [$];

  typedef struct packed {
    qft_mode_e                mode;
    logic [MAX_WORD-1:0][7:0] held;
    logic [7:0]               held_n;
    logic [7:0]               tag_n;
    logic [63:0]              mag;
    logic [2:0]               phase;
    logic [15:0]              offset;
  } scan_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               push;
  logic               full;
  logic [7:0]         query_byte_i;
  logic               empty;
  logic               pop;
  logic [3:0]         token_kind_o;
  logic signed [63:0] int_value_o;
  logic [7:0]         tag_byte_o;
  logic [7:0]         word_length_o;
  logic [1:0]         error_code_o;
  logic [15:0]        error_position_o;
  logic               last_result_o;

  scan_t    scan_st;
  qft_res_t pending_tokens [$];
  int       fail_count = 0;
  int       bytes_sent = 0;
  bit       idle_on    = 1'b1;
  bit       stall_on   = 1'b1;

  query_filter_tokenizer_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .query_byte_i     (query_byte_i),
    .empty            (empty),
    .pop              (pop),
    .token_kind_o     (token_kind_o),
    .int_value_o      (int_value_o),
    .tag_byte_o       (tag_byte_o),
    .word_length_o    (word_length_o),
    .error_code_o     (error_code_o),
    .error_position_o (error_position_o),
    .last_result_o    (last_result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- scanner model

  function automatic scan_t scan_cleared();
    scan_t s;
    s        = '0;
    s.mode   = MODE_IDLE;
    s.phase  = NPH_START;
    return s;
  endfunction

  function automatic bit is_break(input logic [7:0] b);
    return b == CH_SPACE || b == CH_NUL || b == CH_LPAREN || b == CH_RPAREN;
  endfunction

  function automatic string kw_spelling(input int k);
    case (k)
      0:       return "not";
      1:       return "and";
      2:       return "or";
      3:       return "priority";
      4:       return "lte";
      5:       return "gte";
      6:       return "gt";
      default: return "lt";
    endcase
  endfunction

  function automatic qft_res_t make_token(input qft_kind_e kind, input logic [63:0] val,
                                          input logic [7:0] tb, input logic [7:0] len,
                                          input qft_err_e code, input logic [15:0] at_pos);
    qft_res_t t;
    t.kind           = kind;
    t.int_value      = val;
    t.tag_byte       = tb;
    t.word_length    = len;
    t.error_code     = code;
    t.error_position = at_pos;
    t.last_result    = 1'b0;
    return t;
  endfunction

  // strtol-like accumulation, magnitude clamped at 2^63
  function automatic scan_t feed_digit(input scan_t s, input logic [7:0] b);
    bit          dig;
    logic [63:0] d;
    logic [63:0] v;
    dig = b >= CH_ZERO && b <= CH_NINE;
    d   = 64'(b - CH_ZERO);
    case (s.phase)
      NPH_START: begin
        if (b >= CH_TAB && b <= CH_CR) begin
          s.phase = NPH_START;
        end else if (b == CH_PLUS) begin
          s.phase = NPH_PLUS;
        end else if (b == CH_MINUS) begin
          s.phase = NPH_MINUS;
        end else if (dig) begin
          s.mag   = d;
          s.phase = NPH_POS;
        end else begin
          s.phase = NPH_BAD;
        end
      end
      NPH_PLUS, NPH_MINUS: begin
        if (dig) begin
          s.mag   = d;
          s.phase = (s.phase == NPH_PLUS) ? NPH_POS : NPH_NEG;
        end else begin
          s.phase = NPH_BAD;
        end
      end
      NPH_POS, NPH_NEG: begin
        if (dig) begin
          if (s.mag > MAG_CAP / 64'd10) begin
            s.mag = MAG_CAP;
          end else begin
            v     = s.mag * 64'd10 + d;
            s.mag = (v > MAG_CAP) ? MAG_CAP : v;
          end
        end else begin
          s.phase = (s.phase == NPH_POS) ? NPH_POS_END : NPH_NEG_END;
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  // pos is the offset of the byte that ended the word
  function automatic qft_res_t close_word(inout scan_t s, input logic [15:0] pos);
    string       name;
    bit          hit;
    logic [63:0] v;
    s.mode = MODE_IDLE;
    for (int k = 0; k < 8; k++) begin
      name = kw_spelling(k);
      if (name.len() == int'(s.held_n)) begin
        hit = 1'b1;
        for (int i = 0; i < name.len(); i++) begin
          if (s.held[i] != name[i]) hit = 1'b0;
        end
        if (hit) return make_token(qft_kind_e'(KIND_NOT + k), '0, '0, s.held_n, ERR_NONE, '0);
      end
    end
    if (s.phase == NPH_POS || s.phase == NPH_POS_END) begin
      v = (s.mag > MAG_CAP - 64'd1) ? MAG_CAP - 64'd1 : s.mag;
      return make_token(KIND_INT, v, '0, s.held_n, ERR_NONE, '0);
    end
    if (s.phase == NPH_NEG || s.phase == NPH_NEG_END) begin
      return make_token(KIND_INT, -s.mag, '0, s.held_n, ERR_NONE, '0);
    end
    s.mode = MODE_HALT;
    return make_token(KIND_ERROR, '0, '0, s.held_n, ERR_UNKNOWN,
                      16'(pos - {8'd0, s.held_n} + 16'd1));
  endfunction

  // One byte through the scanner; returns how many tokens it yields (0..2)
  function automatic int tokenize_byte(inout scan_t s, input logic [7:0] b,
                                       output qft_res_t r [2]);
    int          n;
    logic [15:0] pos;
    bit          at_idle;
    n       = 0;
    at_idle = 1'b0;
    r[0]    = '0;
    r[1]    = '0;
    if (s.mode == MODE_HALT) return 0;
    pos      = s.offset;
    s.offset = pos + 16'd1;
    case (s.mode)
      MODE_WORD: begin
        if (!is_break(b) && s.held_n < MAX_WORD) begin
          s.held[s.held_n[3:0]] = b;
          s.held_n              = s.held_n + 8'd1;
          s                     = feed_digit(s, b);
        end else begin
          r[n] = close_word(s, pos);
          n++;
          at_idle = (s.mode == MODE_IDLE);
        end
      end
      MODE_TAG: begin
        if (!is_break(b)) begin
          if (int'(s.tag_n) + 1 < MAX_TAG) begin
            r[n]    = make_token(KIND_TAG_BYTE, '0, b, '0, ERR_NONE, '0);
            s.tag_n = s.tag_n + 8'd1;
          end else begin
            s.mode = MODE_HALT;
            r[n]   = make_token(KIND_ERROR, '0, '0, s.tag_n, ERR_TAG_LONG,
                                16'(pos - {8'd0, s.tag_n} + 16'd1));
          end
          n++;
        end else begin
          r[n] = make_token(KIND_TAG_END, '0, '0, s.tag_n, ERR_NONE, '0);
          n++;
          s.mode  = MODE_IDLE;
          at_idle = 1'b1;
        end
      end
      default: at_idle = 1'b1;
    endcase
    if (at_idle) begin
      if (b == CH_NUL) begin
        r[n] = make_token(KIND_EOF, '0, '0, '0, ERR_NONE, '0);
        n++;
        s = scan_cleared();
      end else if (b == CH_LPAREN) begin
        r[n] = make_token(KIND_LPAREN, '0, '0, 8'd1, ERR_NONE, '0);
        n++;
      end else if (b == CH_RPAREN) begin
        r[n] = make_token(KIND_RPAREN, '0, '0, 8'd1, ERR_NONE, '0);
        n++;
      end else if (b == CH_DOT) begin
        s.mode  = MODE_TAG;
        s.tag_n = '0;
      end else if (b != CH_SPACE) begin
        s.mode    = MODE_WORD;
        s.held[0] = b;
        s.held_n  = 8'd1;
        s.mag     = '0;
        s.phase   = NPH_START;
        s         = feed_digit(s, b);
      end
    end
    if (n > 0) r[n-1].last_result = 1'b1;
    return n;
  endfunction

  // Dry run: does this byte run keep the block out of the halted state?
  function automatic bit fragment_safe(input scan_t s, input byte_q_t f);
    qft_res_t r [2];
    int       n;
    foreach (f[i]) begin
      n = tokenize_byte(s, f[i], r);
      for (int j = 0; j < n; j++) begin
        if (r[j].kind == KIND_ERROR) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (is_break(b));
    return b;
  endfunction

  // At most one token-ish chunk followed by one or two separators
  function automatic byte_q_t random_fragment();
    byte_q_t q;
    string   name;
    int      len;
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6: begin
        name = kw_spelling($urandom_range(0, 7));
        foreach (name[i]) q.push_back(name[i]);
      end
      7, 8, 9, 10, 11: begin
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(CH_TAB, CH_CR)));
        end
        case ($urandom_range(0, 2))
          0:       q.push_back(CH_PLUS);
          1:       q.push_back(CH_MINUS);
          default: ;
        endcase
        repeat ($urandom_range(1, 18)) q.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 3) == 0) begin
          repeat ($urandom_range(1, 4)) q.push_back(text_byte());
        end
      end
      12, 13, 14: begin
        q.push_back(CH_DOT);
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, MAX_TAG - 1)
                                           : $urandom_range(0, 8);
        repeat (len) q.push_back(text_byte());
      end
      15, 16: q.push_back($urandom_range(0, 1) ? CH_LPAREN : CH_RPAREN);
      17: repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
      18: q.push_back(CH_NUL);
      default: ;
    endcase
    repeat ($urandom_range(1, 2)) begin
      case ($urandom_range(0, 7))
        0:       q.push_back(CH_LPAREN);
        1:       q.push_back(CH_RPAREN);
        2:       q.push_back(CH_NUL);
        default: q.push_back(CH_SPACE);
      endcase
    end
    return q;
  endfunction

  // ---------------------------------------------------------------- driving and checking

  task automatic send_byte(input logic [7:0] b);
    int       gap;
    int       n;
    qft_res_t r [2];
    gap = idle_on ? $urandom_range(0, 16) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      push         <= 1'b0;
      query_byte_i <= 8'($urandom);
    end
    @(negedge clk_i);
    push         <= 1'b1;
    query_byte_i <= b;
    do @(posedge clk_i); while (full);
    n = tokenize_byte(scan_st, b, r);
    for (int i = 0; i < n; i++) pending_tokens.push_back(r[i]);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic note_failure(input string what, input qft_res_t want);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t %s: exp kind=%0d val=%0d tag=%02h len=%0d err=%0d pos=%0d last=%0b",
               $realtime, what, want.kind, $signed(want.int_value), want.tag_byte,
               want.word_length, want.error_code, want.error_position, want.last_result);
      $display("    got kind=%0d val=%0d tag=%02h len=%0d err=%0d pos=%0d last=%0b",
               token_kind_o, int_value_o, tag_byte_o, word_length_o, error_code_o,
               error_position_o, last_result_o);
    end
  endtask

  task automatic check_token();
    qft_res_t want;
    if (pending_tokens.size() == 0) begin
      note_failure("token with nothing expected", '0);
      return;
    end
    want = pending_tokens.pop_front();
    if (token_kind_o !== want.kind || int_value_o !== want.int_value ||
        tag_byte_o !== want.tag_byte || word_length_o !== want.word_length ||
        error_code_o !== want.error_code || error_position_o !== want.error_position ||
        last_result_o !== want.last_result) begin
      note_failure("token mismatch", want);
    end
  endtask

  // Result side: one transaction per accepted pop, with a random hold before the next
  initial begin : token_sink
    int hold;
    hold = 0;
    pop  = 1'b0;
    forever begin
      @(negedge clk_i);
      pop <= (hold == 0);
      if (hold > 0) hold--;
      @(posedge clk_i);
      if (rst_ni && pop && !empty) begin
        check_token();
        hold = stall_on ? $urandom_range(0, 16) : 0;
      end
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_keywords();
    send_text("(not and)or priority(lte gte)gt lt ");
  endtask

  task automatic test_integers();
    send_text("0 +7 -0 9999999999999999 -999999999999999 42abc 12.5 +3\t ");
    // leading whitespace bytes are skipped
    for (int c = CH_TAB; c <= CH_CR; c++) send_byte(8'(c));
    send_text("-8)");
  endtask

  task automatic test_long_words();
    // the byte past MAX_WORD closes the word and starts the next one
    send_text("1234567890123456not 12345678901234567890)");
  endtask

  task automatic test_tags();
    send_text(".a.b(. ");
    send_byte(CH_DOT);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'h01);
    send_byte(8'h7F);
    send_byte(CH_RPAREN);
    // longest legal tag name
    send_byte(CH_DOT);
    repeat (MAX_TAG - 1) send_byte(text_byte());
    send_byte(CH_SPACE);
  endtask

  task automatic test_end_of_query();
    send_text("and");
    send_byte(CH_NUL);
    send_text(".x");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    send_text("7");
    send_byte(CH_NUL);
  endtask

  task automatic test_random_queries();
    byte_q_t frag;
    int      tries;
    while (bytes_sent < 1550) begin
      if ($urandom_range(0, 15) == 0) idle_on = !idle_on;
      if ($urandom_range(0, 15) == 0) stall_on = !stall_on;
      tries = 0;
      do begin
        frag = random_fragment();
        tries++;
      end while (!fragment_safe(scan_st, frag) && tries < 30);
      if (!fragment_safe(scan_st, frag)) frag = '{CH_SPACE};
      foreach (frag[i]) send_byte(frag[i]);
    end
    idle_on  = 1'b1;
    stall_on = 1'b1;
  endtask

  // Errors halt the block for good, so this runs last
  task automatic test_halt_after_error();
    bit tag_case;
    tag_case = $urandom_range(0, 1);
    send_byte(CH_NUL);
    repeat ($urandom_range(0, 20)) send_byte(CH_SPACE);
    if (tag_case) begin
      send_byte(CH_DOT);
      repeat (MAX_TAG + 1) send_byte(text_byte());
    end else begin
      send_text("bogus!word ");
    end
    // halted: everything ignored, end of query too
    send_byte(CH_NUL);
    send_text("(and 5)");
    send_byte(CH_NUL);
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    int guard;
    rst_ni       = 1'b0;
    push         = 1'b0;
    query_byte_i = '0;
    scan_st      = scan_cleared();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    test_keywords();
    test_integers();
    test_long_words();
    test_tags();
    test_end_of_query();
    test_random_queries();
    test_halt_after_error();

    @(negedge clk_i);
    push <= 1'b0;
    guard = 0;
    while (pending_tokens.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_tokens.size() != 0) note_failure("expected token never arrived",
                                                 pending_tokens[0]);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
